// ===== hw/rtl/bsr_pkg.sv =====
// Shared types, codes and defaults for the shortest-route search block.
// Used by every module under hw/rtl except bsr_fifo; depends on nothing.
`default_nettype none
package bsr_pkg;

   localparam int NODE_W    = 6;
   localparam int DEF_NODES = 64;
   localparam int DEF_EDGES = 256;

   // request function codes
   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_ADD   = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   // classified command codes
   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_ADD     = 2'd1;
   localparam logic [1:0] OP_QUERY   = 2'd2;
   localparam logic [1:0] OP_NOROUTE = 2'd3;

   localparam logic STATUS_HOP     = 1'b0;
   localparam logic STATUS_NOROUTE = 1'b1;

   typedef struct packed {
      logic [1:0]        func;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [NODE_W-1:0] hop_from;
      logic [NODE_W-1:0] hop_to;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } cmd_type;

endpackage
`default_nettype wire

// ===== hw/rtl/bsr_fifo.sv =====
// Small register FIFO with full/empty flags.
// Generic; no package dependency.
`default_nettype none
module bsr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/bsr_front.sv =====
// Front end: accepts request beats, classifies them and queues commands.
// Depends on bsr_pkg and bsr_fifo.
`default_nettype none
module bsr_front #(
   parameter int NODES = bsr_pkg::DEF_NODES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire bsr_pkg::req_type req_data,
   output logic                  req_full,
   input  wire logic             cmd_pop,
   output bsr_pkg::cmd_type      cmd_data,
   output logic                  cmd_empty
);
   import bsr_pkg::*;

   cmd_type cmd;
   logic    keep, a_ok, b_ok;

   always_comb begin
      a_ok = (32'(req_data.node_a) < NODES);
      b_ok = (32'(req_data.node_b) < NODES);
      cmd.node_a = req_data.node_a;
      cmd.node_b = req_data.node_b;
      cmd.op     = OP_CLEAR;
      keep       = 1'b0;
      case (req_data.func)
         FUNC_CLEAR: begin
            cmd.op = OP_CLEAR;
            keep   = 1'b1;
         end
         FUNC_ADD: begin
            // drop edges naming a node out of range
            cmd.op = OP_ADD;
            keep   = a_ok && b_ok;
         end
         FUNC_QUERY: begin
            cmd.op = (a_ok && b_ok) ? OP_QUERY : OP_NOROUTE;
            keep   = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   bsr_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(4)) u_cmd_q (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push && keep),
      .push_data(cmd),
      .full     (req_full),
      .pop      (cmd_pop),
      .pop_data (cmd_data),
      .empty    (cmd_empty)
   );
endmodule
`default_nettype wire

// ===== hw/rtl/bsr_engine.sv =====
// Back end: edge store, breadth-first search and route emission.
// Depends on bsr_pkg.
`default_nettype none
module bsr_engine #(
   parameter int NODES = bsr_pkg::DEF_NODES,
   parameter int EDGES = bsr_pkg::DEF_EDGES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bsr_pkg::cmd_type cmd_data,
   input  wire logic             cmd_empty,
   output logic                  cmd_pop,
   output logic                  rsp_push,
   output bsr_pkg::rsp_type      rsp_item,
   input  wire logic             rsp_full
);
   import bsr_pkg::*;

   localparam int EAW = (EDGES > 1) ? $clog2(EDGES) : 1;
   localparam int ECW = $clog2(EDGES + 1);
   localparam int NIW = $clog2(NODES);
   localparam int NCW = $clog2(NODES + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DEQ    = 4'd1;
   localparam logic [3:0] S_DEQW   = 4'd2;
   localparam logic [3:0] S_SCAN   = 4'd3;
   localparam logic [3:0] S_CHECK  = 4'd4;
   localparam logic [3:0] S_WALK   = 4'd5;
   localparam logic [3:0] S_WALKW  = 4'd6;
   localparam logic [3:0] S_POPR   = 4'd7;
   localparam logic [3:0] S_EMIT   = 4'd8;
   localparam logic [3:0] S_SINGLE = 4'd9;

   logic [2*NODE_W-1:0] edge_mem [EDGES];
   logic [NODE_W-1:0]   pred_mem [NODES];
   logic [NODE_W-1:0]   fq_mem   [NODES];
   logic [NODE_W-1:0]   stack_mem[NODES];

   logic [3:0]          state_ff, state_in;
   logic [ECW-1:0]      count_ff, count_in;
   logic [ECW-1:0]      e_ff, e_in;
   logic [NODES-1:0]    visited_ff, visited_in;
   logic [NCW-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [NCW-1:0]      n_ff, n_in;
   logic [NODE_W-1:0]   a_ff, a_in, b_ff, b_in, u_ff, u_in;
   logic [NODE_W-1:0]   i_ff, i_in, prev_ff, prev_in;
   rsp_type             single_ff, single_in;

   logic [2*NODE_W-1:0] edge_rd_ff;
   logic [NODE_W-1:0]   pred_rd_ff, fq_rd_ff, stack_rd_ff;

   logic                edge_we, edge_re, pred_we, fq_we, fq_re, stack_we, stack_re, pred_re;
   logic [EAW-1:0]      edge_waddr, edge_raddr;
   logic [NIW-1:0]      pred_waddr, fq_waddr, pred_raddr, fq_raddr, stack_addr;
   logic [NODE_W-1:0]   pred_wdata, fq_wdata;
   logic [NODE_W-1:0]   ex, ey, v;
   logic                hit;

   always_comb begin
      ex  = edge_rd_ff[NODE_W-1:0];
      ey  = edge_rd_ff[2*NODE_W-1:NODE_W];
      hit = 1'b1;
      if (ex == u_ff)      v = ey;
      else if (ey == u_ff) v = ex;
      else begin
         v   = ex;
         hit = 1'b0;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      e_in       = e_ff;
      visited_in = visited_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      n_in       = n_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      u_in       = u_ff;
      i_in       = i_ff;
      prev_in    = prev_ff;
      single_in  = single_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      rsp_item   = single_ff;
      edge_we    = 1'b0;
      edge_waddr = count_ff[EAW-1:0];
      edge_re    = 1'b0;
      edge_raddr = '0;
      pred_we    = 1'b0;
      pred_waddr = v[NIW-1:0];
      pred_wdata = u_ff;
      pred_re    = 1'b0;
      pred_raddr = i_ff[NIW-1:0];
      fq_we      = 1'b0;
      fq_waddr   = tail_ff[NIW-1:0];
      fq_wdata   = v;
      fq_re      = 1'b0;
      fq_raddr   = head_ff[NIW-1:0];
      stack_we   = 1'b0;
      stack_re   = 1'b0;
      stack_addr = n_ff[NIW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               a_in    = cmd_data.node_a;
               b_in    = cmd_data.node_b;
               case (cmd_data.op)
                  OP_CLEAR: count_in = '0;
                  OP_ADD: begin
                     if (32'(count_ff) < EDGES) begin
                        edge_we  = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     // seed the search with the start node
                     visited_in = '0;
                     visited_in[cmd_data.node_a[NIW-1:0]] = 1'b1;
                     pred_we    = 1'b1;
                     pred_waddr = cmd_data.node_a[NIW-1:0];
                     pred_wdata = cmd_data.node_a;
                     fq_we      = 1'b1;
                     fq_waddr   = '0;
                     fq_wdata   = cmd_data.node_a;
                     head_in    = '0;
                     tail_in    = NCW'(1);
                     state_in   = S_DEQ;
                  end
                  default: begin
                     single_in = '{STATUS_NOROUTE, '0, '0, 1'b1};
                     state_in  = S_SINGLE;
                  end
               endcase
            end
         end
         S_DEQ: begin
            if (head_ff == tail_ff) state_in = S_CHECK;
            else begin
               fq_re    = 1'b1;
               head_in  = head_ff + 1'b1;
               state_in = S_DEQW;
            end
         end
         S_DEQW: begin
            u_in = fq_rd_ff;
            e_in = '0;
            if (count_ff == '0) state_in = S_DEQ;
            else begin
               edge_re    = 1'b1;
               edge_raddr = '0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            // edge e_ff is on the read port; fetch the next one
            if (hit && !visited_ff[v[NIW-1:0]] && 32'(tail_ff) < NODES) begin
               visited_in[v[NIW-1:0]] = 1'b1;
               pred_we = 1'b1;
               fq_we   = 1'b1;
               tail_in = tail_ff + 1'b1;
            end
            if (e_ff + 1'b1 == count_ff) state_in = S_DEQ;
            else begin
               edge_re    = 1'b1;
               edge_raddr = EAW'(e_ff + 1'b1);
               e_in       = e_ff + 1'b1;
            end
         end
         S_CHECK: begin
            if (!visited_ff[b_ff[NIW-1:0]]) begin
               single_in = '{STATUS_NOROUTE, '0, '0, 1'b1};
               state_in  = S_SINGLE;
            end else if (a_ff == b_ff) begin
               single_in = '{STATUS_HOP, a_ff, a_ff, 1'b1};
               state_in  = S_SINGLE;
            end else begin
               i_in     = b_ff;
               n_in     = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            stack_we = 1'b1;
            pred_re  = 1'b1;
            n_in     = n_ff + 1'b1;
            state_in = S_WALKW;
         end
         S_WALKW: begin
            i_in = pred_rd_ff;
            if (pred_rd_ff == a_ff) begin
               prev_in  = a_ff;
               state_in = S_POPR;
            end else state_in = S_WALK;
         end
         S_POPR: begin
            stack_re   = 1'b1;
            stack_addr = NIW'(n_ff - 1'b1);
            n_in       = n_ff - 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            rsp_item = '{STATUS_HOP, prev_ff, stack_rd_ff, (n_ff == '0)};
            if (!rsp_full) begin
               rsp_push = 1'b1;
               prev_in  = stack_rd_ff;
               state_in = (n_ff == '0) ? S_IDLE : S_POPR;
            end
         end
         S_SINGLE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         visited_ff <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         visited_ff <= visited_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff      <= e_in;
      n_ff      <= n_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      u_ff      <= u_in;
      i_ff      <= i_in;
      prev_ff   <= prev_in;
      single_ff <= single_in;
   end

   always_ff @(posedge clock) begin
      if (edge_we) edge_mem[edge_waddr] <= {cmd_data.node_b, cmd_data.node_a};
      if (edge_re) edge_rd_ff <= edge_mem[edge_raddr];
   end

   always_ff @(posedge clock) begin
      if (pred_we) pred_mem[pred_waddr] <= pred_wdata;
      if (pred_re) pred_rd_ff <= pred_mem[pred_raddr];
   end

   always_ff @(posedge clock) begin
      if (fq_we) fq_mem[fq_waddr] <= fq_wdata;
      if (fq_re) fq_rd_ff <= fq_mem[fq_raddr];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[stack_addr] <= i_ff;
      if (stack_re) stack_rd_ff <= stack_mem[stack_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/bfs_shortest_route_top.sv =====
// Top level of the breadth-first shortest-route block.
// Depends on bsr_pkg, bsr_front, bsr_engine and bsr_fifo.
//
//   channel  ports                         direction  beat accepted when
//   request  req_push req_full req_data    in         req_push && !req_full
//   response rsp_pop rsp_empty rsp_data    out        rsp_pop && !rsp_empty
//
// Clear and add-edge beats are handled in the back end's idle state; the front queue
// absorbs a burst of four. A query scans every stored edge in turn for each node
// it visits, then walks the predecessors back from the destination onto a stack
// and pops it to emit one beat per route hop. A single-beat answer is sent from
// its own state.
// Reset is synchronous and active high; it empties both queues and the graph.
// A full response queue stalls the back end; the front keeps taking beats
// until its own queue fills.
`default_nettype none
module bfs_shortest_route_top #(
   parameter int NODES = bsr_pkg::DEF_NODES,
   parameter int EDGES = bsr_pkg::DEF_EDGES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire bsr_pkg::req_type req_data,
   output logic                  req_full,
   input  wire logic             rsp_pop,
   output bsr_pkg::rsp_type      rsp_data,
   output logic                  rsp_empty
);
   import bsr_pkg::*;

   cmd_type cmd_data;
   logic    cmd_empty, cmd_pop;
   rsp_type rsp_item;
   logic    rsp_push, rsp_full;

   // classify and queue request beats
   bsr_front #(.NODES(NODES)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd_pop  (cmd_pop),
      .cmd_data (cmd_data),
      .cmd_empty(cmd_empty)
   );

   // run commands: edge store, search, route walk
   bsr_engine #(.NODES(NODES), .EDGES(EDGES)) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cmd_data (cmd_data),
      .cmd_empty(cmd_empty),
      .cmd_pop  (cmd_pop),
      .rsp_push (rsp_push),
      .rsp_item (rsp_item),
      .rsp_full (rsp_full)
   );

   // hold results until the consumer pops them
   bsr_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(4)) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .push_data(rsp_item),
      .full     (rsp_full),
      .pop      (rsp_pop),
      .pop_data (rsp_data),
      .empty    (rsp_empty)
   );
endmodule
`default_nettype wire

// ===== hw/rtl/bsr_checker.sv =====
// Port-level checks for the shortest-route block, bound to its top level.
// Depends on bsr_pkg.
`default_nettype none
module bsr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_full,
   input wire logic             rsp_pop,
   input wire logic             rsp_empty,
   input wire bsr_pkg::rsp_type rsp_data
);
   import bsr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("stalled response beat changed");

   a_noroute_form: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.status == STATUS_NOROUTE |->
         rsp_data.last && rsp_data.hop_from == '0 && rsp_data.hop_to == '0)
      else $error("malformed no-route beat");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> rsp_empty)
      else $error("response queue not empty after reset");

   a_reset_ready: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_full)
      else $error("request queue full after reset");
endmodule

bind bfs_shortest_route_top bsr_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_full (req_full),
   .rsp_pop  (rsp_pop),
   .rsp_empty(rsp_empty),
   .rsp_data (rsp_data)
);
`default_nettype wire

// ===== test/bsr_route_checker.sv =====
// Checker for the shortest-route block: watches both queue channels, predicts
// every response beat from the request beats and compares them in order.
// Depends on bsr_pkg only.
`timescale 1ns / 100ps
module bsr_route_checker #(
   parameter int NODES = 64,
   parameter int EDGES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  bsr_pkg::req_type req_data,
   input  logic             rsp_pop,
   input  logic             rsp_empty,
   input  bsr_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import bsr_pkg::*;

   logic [5:0] edge_a [EDGES];
   logic [5:0] edge_b [EDGES];
   int         num_edges;
   rsp_type    route_q [$];

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      fail_count++;
   endtask

   function automatic rsp_type mk(logic st, logic [5:0] f, logic [5:0] t, logic l);
      rsp_type r;
      r.status = st; r.hop_from = f; r.hop_to = t; r.last = l;
      return r;
   endfunction

   task automatic solve_route(input int src, input int dst);
      bit seen [NODES];
      int parent [NODES];
      int fifo [$];
      int path [$];
      int u, v, i, prev;
      if (src >= NODES || dst >= NODES) begin
         route_q.insert(route_q.size(), mk(STATUS_NOROUTE, 6'd0, 6'd0, 1'b1));
         return;
      end
      foreach (seen[j]) seen[j] = 0;
      seen[src] = 1; parent[src] = src;
      fifo.insert(fifo.size(), src);
      while (fifo.size() > 0) begin
         u = fifo.pop_front();
         for (int e = 0; e < num_edges; e++) begin
            if (int'(edge_a[e]) == u) v = int'(edge_b[e]);
            else if (int'(edge_b[e]) == u) v = int'(edge_a[e]);
            else continue;
            if (!seen[v]) begin
               seen[v] = 1; parent[v] = u; fifo.insert(fifo.size(), v);
            end
         end
      end
      if (!seen[dst]) begin
         route_q.insert(route_q.size(), mk(STATUS_NOROUTE, 6'd0, 6'd0, 1'b1));
         return;
      end
      if (src == dst) begin
         route_q.insert(route_q.size(), mk(STATUS_HOP, 6'(src), 6'(src), 1'b1));
         return;
      end
      i = dst;
      while (i != src) begin
         path.push_front(i);
         i = parent[i];
      end
      prev = src;
      foreach (path[j]) begin
         route_q.insert(route_q.size(),
                        mk(STATUS_HOP, 6'(prev), 6'(path[j]), j == path.size() - 1));
         prev = path[j];
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         num_edges = 0;
         route_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (route_q.size() == 0)
               report($sformatf("unexpected beat %p", rsp_data));
            else begin
               rsp_type want;
               want = route_q.pop_front();
               if (rsp_data.status !== want.status || rsp_data.hop_from !== want.hop_from
                   || rsp_data.hop_to !== want.hop_to || rsp_data.last !== want.last)
                  report($sformatf("got %p want %p", rsp_data, want));
            end
         end
         if (req_push && !req_full) begin
            case (req_data.func)
               FUNC_CLEAR: num_edges = 0;
               FUNC_ADD:
                  if (num_edges < EDGES && req_data.node_a < NODES
                      && req_data.node_b < NODES) begin
                     edge_a[num_edges] = req_data.node_a;
                     edge_b[num_edges] = req_data.node_b;
                     num_edges++;
                  end
               FUNC_QUERY: solve_route(int'(req_data.node_a), int'(req_data.node_b));
               default: ;
            endcase
         end
      end
      pending = route_q.size();
   end
endmodule

// ===== test/tb_top.sv =====
// Testbench top for bfs_shortest_route_top: drives request beats with random
// gaps and pops responses with random stalls. Depends on bsr_pkg and the checker.
`timescale 1ns / 100ps
module tb_top;
   import bsr_pkg::*;

   // function code the block ignores
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_push = 0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_pop = 0;
   rsp_type rsp_data;
   logic    rsp_empty;
   int      fail_count, pending;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   bfs_shortest_route_top u_top (.*);

   bsr_route_checker u_chk (.*);

   function automatic int gap_len();
      // mostly short gaps, a few long ones
      if ($urandom_range(9) < 6) return 0;
      if ($urandom_range(9) < 8) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Receiver: stall at random, on the falling edge.
   initial begin
      int stall;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_pop <= 0; stall--;
         end else begin
            rsp_pop <= 1; stall = gap_len();
         end
      end
   end

   // Send one beat: hold push until a rising edge accepts it. Push stays high
   // into the next beat unless a gap follows.
   task automatic send(input logic [1:0] f, input logic [5:0] a, input logic [5:0] b);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_push <= 0;
         repeat (g) @(negedge clock);
      end
      req_data <= '{func: f, node_a: a, node_b: b};
      req_push <= 1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   // Clear, build a random graph over nodes 0 to span, then ask questions on it.
   task automatic random_phase(input int span);
      int n;
      send(FUNC_CLEAR, 6'($urandom), 6'($urandom));
      n = $urandom_range(20, 2);
      repeat (n) send(FUNC_ADD, 6'($urandom_range(span)), 6'($urandom_range(span)));
      repeat ($urandom_range(4, 1))
         send(FUNC_QUERY, 6'($urandom_range(span)), 6'($urandom_range(span)));
      if ($urandom_range(5) == 0) send(FUNC_SPARE, 6'($urandom), 6'($urandom));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: empty graph, self query, chain, extremes, no route, spare code
      send(FUNC_QUERY, 0, 0);
      send(FUNC_QUERY, 63, 0);
      send(FUNC_ADD, 0, 1);
      send(FUNC_ADD, 1, 2);
      send(FUNC_ADD, 2, 63);
      send(FUNC_ADD, 5, 5);
      send(FUNC_ADD, 0, 63);
      send(FUNC_QUERY, 0, 63);
      send(FUNC_QUERY, 63, 2);
      send(FUNC_QUERY, 5, 5);
      send(FUNC_QUERY, 5, 0);
      send(FUNC_QUERY, 1, 1);
      send(FUNC_SPARE, 63, 63);
      send(FUNC_CLEAR, 0, 0);
      send(FUNC_QUERY, 0, 1);
      // long chain to reach a deep route
      for (int i = 0; i < 63; i++) send(FUNC_ADD, 6'(i), 6'(i + 1));
      send(FUNC_QUERY, 0, 63);
      // hold off until every expected beat has drained
      req_push <= 0;
      wait (pending == 0);
      repeat (20) @(negedge clock);
      for (int p = 0; p < 4; p++) random_phase(p < 2 ? 7 : 63);
      req_push <= 0;
      wait (pending == 0);
      repeat (2000) @(negedge clock);
      if (fail_count == 0)
         $display("[bfs_shortest_route_top] OK");
      else
         $display("[bfs_shortest_route_top] ERROR");
      $finish;
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("[bfs_shortest_route_top] ERROR");
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/bsr_pkg.sv
hw/rtl/bsr_fifo.sv
hw/rtl/bsr_front.sv
hw/rtl/bsr_engine.sv
hw/rtl/bfs_shortest_route_top.sv
hw/rtl/bsr_checker.sv
test/bsr_route_checker.sv
test/tb_top.sv
